@@ rtl/lprl_pkg.sv @@
package lprl_pkg;

    localparam int ROUTES_DEF    = 32;
    localparam int PORT_BITS_DEF = 4;

    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 6;
    localparam int IDX_FIELD_W = 5;
    localparam int PORT_FIELD_W = 4;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 16;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    // item travelling down the cell row, with the best match found so far
    typedef struct packed {
        logic              vld;
        logic              lookup;
        logic [ADDR_W-1:0] addr;
        logic              found;
        logic [LEN_W-1:0]  len;
    } t_probe;

    function automatic logic [3:0] ones8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            n = n + 4'(v[k]);
        end
        return n;
    endfunction

    function automatic logic [LEN_W-1:0] mask_len(input logic [ADDR_W-1:0] m);
        return LEN_W'(ones8(m[7:0])) + LEN_W'(ones8(m[15:8]))
             + LEN_W'(ones8(m[23:16])) + LEN_W'(ones8(m[31:24]));
    endfunction

endpackage

@@ rtl/lprl_cell.sv @@
module lprl_cell #(
    parameter int IDX_W     = 5,
    parameter int PORT_BITS = 4,
    parameter int CELL_IDX  = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic                          i_wr_valid,
    input  logic [lprl_pkg::ADDR_W-1:0]   i_wr_prefix,
    input  logic [lprl_pkg::ADDR_W-1:0]   i_wr_mask,
    input  logic [PORT_BITS-1:0]          i_wr_port,
    input  logic                          i_adv,
    input  lprl_pkg::t_probe              i_probe,
    input  logic [IDX_W-1:0]              i_best_idx,
    input  logic [PORT_BITS-1:0]          i_best_port,
    output lprl_pkg::t_probe              o_probe,
    output logic [IDX_W-1:0]              o_best_idx,
    output logic [PORT_BITS-1:0]          o_best_port
);
    import lprl_pkg::*;

    logic                 r_valid;
    logic [ADDR_W-1:0]    r_prefix;
    logic [ADDR_W-1:0]    r_mask;
    logic [LEN_W-1:0]     r_len;
    logic [PORT_BITS-1:0] r_port;

    t_probe               r_probe;
    logic [IDX_W-1:0]     r_best_idx;
    logic [PORT_BITS-1:0] r_best_port;

    t_probe               n_probe;
    logic [IDX_W-1:0]     n_best_idx;
    logic [PORT_BITS-1:0] n_best_port;
    logic                 w_match;
    logic                 w_take;

    always_comb begin
        w_match = i_probe.lookup && r_valid
                  && (((i_probe.addr ^ r_prefix) & r_mask) == '0);
        w_take  = w_match && (!i_probe.found || (r_len > i_probe.len));
        n_probe     = i_probe;
        n_best_idx  = i_best_idx;
        n_best_port = i_best_port;
        if (w_take) begin
            n_probe.found = 1'b1;
            n_probe.len   = r_len;
            n_best_idx    = IDX_W'(CELL_IDX);
            n_best_port   = r_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_valid <= i_wr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_prefix <= i_wr_prefix;
            r_mask   <= i_wr_mask;
            r_len    <= mask_len(i_wr_mask);
            r_port   <= i_wr_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe     <= '0;
            r_best_idx  <= '0;
            r_best_port <= '0;
        end else if (i_adv) begin
            r_probe     <= n_probe;
            r_best_idx  <= n_best_idx;
            r_best_port <= n_best_port;
        end
    end

    assign o_probe     = r_probe;
    assign o_best_idx  = r_best_idx;
    assign o_best_port = r_best_port;

endmodule

@@ rtl/longest_prefix_route_lookup.sv @@
// Longest-prefix route table with IPv4 lookup.
// Input stream: s_axis_tuser selects the item kind (write one slot or look up
// an address); s_axis_tdata carries the slot fields and the lookup address.
// Output stream: one item per input item, hit/port/index in m_axis_tdata;
// a write returns all zeros.
// Each slot lives in one cell of a row of ROUTES cells. An item enters cell 0
// on acceptance and moves one cell per cycle while the row advances, each cell
// comparing it against its own slot and keeping the longest mask seen so far
// (lowest slot on a tie). Writes load the addressed cell at acceptance and then
// follow the same path. The last cell feeds the output register, which drives
// m_axis_tvalid. A new item is taken only once the last one has left the row;
// s_axis_tready is low while an item is in the row.
// A new item may be accepted while the previous result still waits in the
// output register. If the receiver stalls, the item at the end of the row
// holds there and the row freezes until the output register frees.
// Reset (synchronous, active low) clears every slot valid bit, the row and the
// output valid bit; slot contents and output data stay undefined until loaded.
module longest_prefix_route_lookup #(
    parameter int ROUTES    = lprl_pkg::ROUTES_DEF,
    parameter int PORT_BITS = lprl_pkg::PORT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_index, entry_valid, entry_prefix, entry_netmask, entry_port,
    // lookup_address, zero pad
    input  logic [lprl_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // operation
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // hit, out_port, matched_index, zero pad
    output logic [lprl_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import lprl_pkg::*;

    localparam int IDX_W = $clog2(ROUTES);
    localparam int CMP_W = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;

    logic [IDX_FIELD_W-1:0]  w_entry_index;
    logic                    w_entry_valid;
    logic [ADDR_W-1:0]       w_entry_prefix;
    logic [ADDR_W-1:0]       w_entry_mask;
    logic [PORT_FIELD_W-1:0] w_entry_port;
    logic [ADDR_W-1:0]       w_lookup_addr;

    logic   w_in_acc;
    logic   w_wr_acc;
    logic   w_adv;
    logic   w_out_load;
    logic   w_out_free;

    t_probe               w_probe [ROUTES+1];
    logic [IDX_W-1:0]     w_idx   [ROUTES+1];
    logic [PORT_BITS-1:0] w_port  [ROUTES+1];
    logic [ROUTES-1:0]    w_wr_en;

    logic                    r_busy;
    logic                    r_out_vld;
    logic                    r_out_hit;
    logic [PORT_FIELD_W-1:0] r_out_port;
    logic [IDX_FIELD_W-1:0]  r_out_idx;

    assign w_entry_index  = s_axis_tdata[4:0];
    assign w_entry_valid  = s_axis_tdata[5];
    assign w_entry_prefix = s_axis_tdata[37:6];
    assign w_entry_mask   = s_axis_tdata[69:38];
    assign w_entry_port   = s_axis_tdata[73:70];
    assign w_lookup_addr  = s_axis_tdata[105:74];

    assign s_axis_tready = !r_busy;
    assign w_in_acc      = s_axis_tvalid && !r_busy;
    assign w_wr_acc      = w_in_acc && (t_op'(s_axis_tuser) == OP_WRITE);

    assign w_out_free = !r_out_vld || m_axis_tready;
    assign w_out_load = w_probe[ROUTES].vld && w_out_free;
    assign w_adv      = !(w_probe[ROUTES].vld && !w_out_free);

    assign w_probe[0] = '{
        vld:    w_in_acc,
        lookup: (t_op'(s_axis_tuser) == OP_LOOKUP),
        addr:   w_lookup_addr,
        found:  1'b0,
        len:    {LEN_W{1'b0}}
    };
    assign w_idx[0]  = '0;
    assign w_port[0] = '0;

    for (genvar g = 0; g < ROUTES; g++) begin : g_cell
        assign w_wr_en[g] = w_wr_acc && (CMP_W'(w_entry_index) == CMP_W'(g));

        lprl_cell #(
            .IDX_W     (IDX_W),
            .PORT_BITS (PORT_BITS),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (w_wr_en[g]),
            .i_wr_valid  (w_entry_valid),
            .i_wr_prefix (w_entry_prefix),
            .i_wr_mask   (w_entry_mask),
            .i_wr_port   (PORT_BITS'(w_entry_port)),
            .i_adv       (w_adv),
            .i_probe     (w_probe[g]),
            .i_best_idx  (w_idx[g]),
            .i_best_port (w_port[g]),
            .o_probe     (w_probe[g+1]),
            .o_best_idx  (w_idx[g+1]),
            .o_best_port (w_port[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_out_load) begin
                r_busy <= 1'b0;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_hit  <= w_probe[ROUTES].found;
            r_out_port <= PORT_FIELD_W'(w_port[ROUTES]);
            r_out_idx  <= IDX_FIELD_W'(w_idx[ROUTES]);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'b0, r_out_idx, r_out_port, r_out_hit};

endmodule

@@ rtl/lprl_chk.sv @@
module lprl_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [lprl_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import lprl_pkg::*;

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output item changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while the row is busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[9:1] == '0)
        else $error("miss item carries port or index");

endmodule

bind longest_prefix_route_lookup lprl_chk u_lprl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ verif/tb_longest_prefix_route_lookup.sv @@
`timescale 1ns / 100ps

module tb_longest_prefix_route_lookup;

    import lprl_pkg::*;

    localparam int NUM_ROUTES     = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = NUM_ROUTES + 8;

    typedef struct packed {
        logic       hit;
        logic [3:0] port;
        logic [4:0] idx;
    } route_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // entry_index, entry_valid, entry_prefix, entry_netmask, entry_port,
    // lookup_address, zero pad
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // operation
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // hit, out_port, matched_index, zero pad
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // predictor copy of the route table
    logic        table_ok  [NUM_ROUTES];
    logic [31:0] table_net [NUM_ROUTES];
    logic [31:0] table_msk [NUM_ROUTES];
    logic [3:0]  table_out [NUM_ROUTES];

    // stimulus-side view of what has been written, used to aim lookups and to copy networks for ties
    logic        aim_ok  [NUM_ROUTES];
    logic [31:0] aim_net [NUM_ROUTES];
    logic [31:0] aim_msk [NUM_ROUTES];

    route_result_t expected_routes[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int errors        = 0;
    int quiet_cycles  = 0;
    int n_writes      = 0;
    int n_lookups     = 0;
    int n_hits        = 0;
    int n_misses      = 0;

    longest_prefix_route_lookup uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        if (errors < 40) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        errors++;
    endtask

    // updates the table on a write, otherwise finds the longest matching mask; queues the expected result either way
    task automatic predict_route(input t_op op, input logic [4:0] idx, input logic vld,
                                 input logic [31:0] pfx, input logic [31:0] msk,
                                 input logic [3:0] port, input logic [31:0] addr);
        route_result_t r;
        int best_len;
        int len;
        r = '0;
        best_len = -1;
        if (op == OP_WRITE) begin
            table_ok[idx]  = vld;
            table_net[idx] = pfx;
            table_msk[idx] = msk;
            table_out[idx] = port;
            n_writes++;
        end else begin
            for (int i = 0; i < NUM_ROUTES; i++) begin
                if (table_ok[i] && ((addr & table_msk[i]) == (table_net[i] & table_msk[i]))) begin
                    len = 0;
                    for (int b = 0; b < 32; b++) len += table_msk[i][b];
                    if (len > best_len) begin
                        best_len = len;
                        r.hit    = 1'b1;
                        r.port   = table_out[i];
                        r.idx    = 5'(i);
                    end
                end
            end
            n_lookups++;
            if (r.hit) n_hits++;
            else n_misses++;
        end
        expected_routes.push_back(r);
    endtask

    always @(posedge i_clk) begin : monitor
        route_result_t got;
        route_result_t want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit  = m_axis_tdata[0];
                got.port = m_axis_tdata[4:1];
                got.idx  = m_axis_tdata[9:5];
                if (expected_routes.size() == 0) begin
                    flag_mismatch($sformatf("result with nothing expected: %h", m_axis_tdata));
                end else begin
                    want = expected_routes.pop_front();
                    if (got.hit !== want.hit)
                        flag_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
                    if (got.port !== want.port)
                        flag_mismatch($sformatf("out_port %0d, expected %0d",
                                                got.port, want.port));
                    if (got.idx !== want.idx)
                        flag_mismatch($sformatf("matched_index %0d, expected %0d",
                                                got.idx, want.idx));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_route(t_op'(s_axis_tuser), s_axis_tdata[4:0], s_axis_tdata[5],
                              s_axis_tdata[37:6], s_axis_tdata[69:38],
                              s_axis_tdata[73:70], s_axis_tdata[105:74]);
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_routes.size());
            $display("longest_prefix_route_lookup regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // leaves tvalid high on return so a following item needs no second drive
    task automatic send_item(input t_op op, input logic [4:0] idx, input logic vld,
                             input logic [31:0] pfx, input logic [31:0] msk,
                             input logic [3:0] port, input logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b0, addr, port, msk, pfx, vld, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_WRITE) begin
            aim_ok[idx]  = vld;
            aim_net[idx] = pfx;
            aim_msk[idx] = msk;
        end
    endtask

    task automatic write_route(input logic [4:0] idx, input logic vld, input logic [31:0] pfx,
                               input logic [31:0] msk, input logic [3:0] port);
        send_item(OP_WRITE, idx, vld, pfx, msk, port, $urandom);
    endtask

    task automatic lookup(input logic [31:0] addr);
        send_item(OP_LOOKUP, 5'($urandom), 1'($urandom), $urandom, $urandom, 4'($urandom), addr);
    endtask

    // drops tvalid and lets the monitor log the item just accepted before waiting on the queue
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_routes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        lookup(32'h0000_0000);
        lookup(32'hFFFF_FFFF);
    endtask

    task automatic test_default_and_host_routes();
        write_route(5'd0, 1'b1, 32'h0000_0000, 32'h0000_0000, 4'd3);
        lookup(32'hFFFF_FFFF);
        write_route(5'd17, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd9);
        lookup(32'hFFFF_FFFF);
        lookup(32'hFFFF_FFFE);
    endtask

    task automatic test_ties_and_noncontiguous();
        // prefix bits beyond the mask are set on purpose
        write_route(5'd31, 1'b1, 32'h0AFF_FFFF, 32'hFF00_0000, 4'd15);
        lookup(32'h0A12_3456);
        write_route(5'd5, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 4'd7);
        lookup(32'h0A00_0001);
        write_route(5'd9, 1'b1, 32'hA0B0_C0D0, 32'hF0F0_F0F0, 4'd12);
        lookup(32'hAFBF_CFDF);
        write_route(5'd8, 1'b1, 32'h0A0B_0000, 32'hFFFF_0000, 4'd1);
        lookup(32'hAFBF_CFDF);
    endtask

    task automatic test_clear_slots();
        write_route(5'd5, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        lookup(32'h0A00_0001);
        write_route(5'd0, 1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0);
        lookup(32'h0102_0304);
        write_route(5'd31, 1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0);
        lookup(32'h0A00_0001);
        wait_for_results();
    endtask

    task automatic random_write();
        logic [4:0]  idx;
        logic [31:0] msk;
        logic [31:0] pfx;
        int          len;
        int          src;
        idx = 5'($urandom);
        pfx = $urandom;
        case ($urandom_range(9))
            0: len = 0;
            1: len = 32;
            default: len = $urandom_range(32);
        endcase
        msk = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
        if ($urandom_range(9) == 0) msk = $urandom;
        if ($urandom_range(6) == 0) begin
            // same network in a second slot to make ties
            src = $urandom_range(NUM_ROUTES - 1);
            if (aim_ok[src]) begin
                pfx = aim_net[src];
                msk = aim_msk[src];
            end
        end
        write_route(idx, ($urandom_range(99) < 85), pfx, msk, 4'($urandom));
    endtask

    task automatic random_lookup();
        int          slot;
        logic [31:0] addr;
        addr = $urandom;
        if ($urandom_range(3) != 0) begin
            for (int k = 0; k < 6; k++) begin
                slot = $urandom_range(NUM_ROUTES - 1);
                if (aim_ok[slot]) begin
                    addr = (aim_net[slot] & aim_msk[slot]) | ($urandom & ~aim_msk[slot]);
                    break;
                end
            end
        end
        lookup(addr);
    endtask

    task automatic test_random_traffic(input int n, input int idle_pct, input int stalls);
        send_idle_pct = idle_pct;
        stall_pct     = stalls;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 30) random_write();
            else random_lookup();
            if (i % 120 == 119) begin
                wait_for_results();
            end
        end
        wait_for_results();
    endtask

    initial begin
        for (int i = 0; i < NUM_ROUTES; i++) aim_ok[i] = 1'b0;
        for (int i = 0; i < NUM_ROUTES; i++) table_ok[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_default_and_host_routes();
        test_ties_and_noncontiguous();
        test_clear_slots();

        test_random_traffic(350, 0, 0);
        test_random_traffic(320, 85, 0);
        test_random_traffic(320, 0, 85);
        test_random_traffic(320, 8, 8);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_routes.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", expected_routes.size()));
        end
        $display("covered %0d table writes and %0d lookups (%0d hits, %0d misses)",
                 n_writes, n_lookups, n_hits, n_misses);
        $display("incl. default and host routes, ties, non-contiguous masks, cleared slots");
        if (errors == 0) begin
            $display("longest_prefix_route_lookup regression: pass");
        end else begin
            $display("longest_prefix_route_lookup regression: fail");
        end
        $finish;
    end

endmodule

@@ longest_prefix_route_lookup.f @@
rtl/lprl_pkg.sv
rtl/lprl_cell.sv
rtl/longest_prefix_route_lookup.sv
rtl/lprl_chk.sv
verif/tb_longest_prefix_route_lookup.sv
